### design/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types, character codes and lookup functions for the terminal
// escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

   // Character codes used by the escape grammar
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_SS3     = 8'h4F;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_F       = 8'h46;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_1       = 8'h31;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_4       = 8'h34;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_6       = 8'h36;
   localparam logic [7:0] CH_7       = 8'h37;
   localparam logic [7:0] CH_8       = 8'h38;

   // Input beat operation
   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_TIMEOUT = 1'b1
   } op_type;

   // Decoder phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ESC   = 2'd1,
      PH_FIRST = 2'd2,
      PH_DIGIT = 2'd3
   } phase_type;

   // Key kinds on the result channel
   typedef enum logic [3:0] {
      K_PLAIN  = 4'd0,
      K_LEFT   = 4'd1,
      K_RIGHT  = 4'd2,
      K_UP     = 4'd3,
      K_DOWN   = 4'd4,
      K_DELETE = 4'd5,
      K_HOME   = 4'd6,
      K_END    = 4'd7,
      K_PGUP   = 4'd8,
      K_PGDN   = 4'd9
   } key_kind_type;

   // Decoder result handed to the output register
   typedef struct packed {
      logic         emit;
      key_kind_type kind;
      logic [7:0]   key_byte;
   } result_type;

   // Final letter of ESC [ x
   function automatic key_kind_type bracket_letter(input logic [7:0] b);
      key_kind_type k;
      case (b)
         CH_A:    k = K_UP;
         CH_B:    k = K_DOWN;
         CH_C:    k = K_RIGHT;
         CH_D:    k = K_LEFT;
         CH_H:    k = K_HOME;
         CH_F:    k = K_END;
         default: k = K_PLAIN;
      endcase
      return k;
   endfunction

   // Digit of ESC [ d ~
   function automatic key_kind_type tilde_digit(input logic [7:0] d);
      key_kind_type k;
      case (d)
         CH_1, CH_7: k = K_HOME;
         CH_3:       k = K_DELETE;
         CH_4, CH_8: k = K_END;
         CH_5:       k = K_PGUP;
         CH_6:       k = K_PGDN;
         default:    k = K_PLAIN;
      endcase
      return k;
   endfunction

   // A named key, or a plain ESC when nothing matched
   function automatic result_type key_or_esc(input key_kind_type k);
      result_type r;
      r.emit = 1'b1;
      r.kind = k;
      r.key_byte = (k == K_PLAIN) ? CH_ESC : 8'h00;
      return r;
   endfunction

endpackage

### design/terminal_escape_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_unit
// Turns a keyboard byte stream with timeout ticks into key events.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid req_stall req_operation       | in
//          | req_byte_value                          |
//  result  | rsp_valid rsp_stall rsp_key_kind        | out
//          | rsp_key_byte                            |
//
// A beat is taken every cycle while req_stall is low; a beat that yields a key
// passes the input register, then the result register, before it shows on the result ports.
// The decode is one pass of logic between the two registers, set by the
// three-register sequence state.
// Synchronous reset returns to idle and empties both registers.
// A stalled result holds; the input register still advances when the
// result register is empty, or when the held beat yields no key and so loads nothing.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_key_kind,
   output logic [7:0] rsp_key_byte
);

   logic                 in_valid_ff;
   tekd_pkg::op_type     in_op_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   tekd_pkg::key_kind_type out_kind_ff;
   logic [7:0]           out_byte_ff;
   tekd_pkg::result_type result;
   logic                 out_free;
   logic                 advance;

   // Consume the held beat when the result register can take its key, or when it yields none
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (out_free || !result.emit);
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff   <= tekd_pkg::op_type'(req_operation);
         in_byte_ff <= req_byte_value;
      end
   end

   tekd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .operation  (in_op_ff),
      .byte_value (in_byte_ff),
      .result     (result)
   );

   // Result register: load a new key, drop the one taken, else hold
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance && result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && result.emit) begin
         out_kind_ff <= result.kind;
         out_byte_ff <= result.key_byte;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_key_kind = out_kind_ff;
   assign rsp_key_byte = out_byte_ff;

endmodule

### design/tekd_decode.sv
// ----------------------------------------------------------------------------
// tekd_decode
// Sequence state and single-pass decode of one registered input beat.
// ----------------------------------------------------------------------------
module tekd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  tekd_pkg::op_type     operation,
   input  logic [7:0]           byte_value,
   output tekd_pkg::result_type result
);

   tekd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          digit_ff, digit_in;

   // Hold sequence state; advance only when the beat is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tekd_pkg::PH_IDLE;
         first_ff <= 8'h00;
         digit_ff <= 8'h00;
      end else if (advance) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         digit_ff <= digit_in;
      end
   end

   // Decode the beat against the current phase
   always_comb begin
      phase_in        = phase_ff;
      first_in        = first_ff;
      digit_in        = digit_ff;
      result.emit     = 1'b0;
      result.kind     = tekd_pkg::K_PLAIN;
      result.key_byte = 8'h00;

      if (operation == tekd_pkg::OP_TIMEOUT) begin
         // Timeout inside a sequence: give up with a plain ESC
         if (phase_ff != tekd_pkg::PH_IDLE) begin
            result   = tekd_pkg::key_or_esc(tekd_pkg::K_PLAIN);
            phase_in = tekd_pkg::PH_IDLE;
         end
      end else begin
         case (phase_ff)
            tekd_pkg::PH_IDLE: begin
               if (byte_value == tekd_pkg::CH_ESC) begin
                  phase_in = tekd_pkg::PH_ESC;
               end else begin
                  result.emit     = 1'b1;
                  result.key_byte = byte_value;
               end
            end
            tekd_pkg::PH_ESC: begin
               first_in = byte_value;
               phase_in = tekd_pkg::PH_FIRST;
            end
            tekd_pkg::PH_FIRST: begin
               phase_in = tekd_pkg::PH_IDLE;
               if (first_ff == tekd_pkg::CH_BRACKET) begin
                  if (byte_value inside {[tekd_pkg::CH_ZERO:tekd_pkg::CH_NINE]}) begin
                     digit_in = byte_value;
                     phase_in = tekd_pkg::PH_DIGIT;
                  end else begin
                     result = tekd_pkg::key_or_esc(tekd_pkg::bracket_letter(byte_value));
                  end
               end else if (first_ff == tekd_pkg::CH_SS3 &&
                            byte_value == tekd_pkg::CH_H) begin
                  result = tekd_pkg::key_or_esc(tekd_pkg::K_HOME);
               end else if (first_ff == tekd_pkg::CH_SS3 &&
                            byte_value == tekd_pkg::CH_F) begin
                  result = tekd_pkg::key_or_esc(tekd_pkg::K_END);
               end else begin
                  result = tekd_pkg::key_or_esc(tekd_pkg::K_PLAIN);
               end
            end
            tekd_pkg::PH_DIGIT: begin
               phase_in = tekd_pkg::PH_IDLE;
               if (byte_value == tekd_pkg::CH_TILDE) begin
                  result = tekd_pkg::key_or_esc(tekd_pkg::tilde_digit(digit_ff));
               end else begin
                  result = tekd_pkg::key_or_esc(tekd_pkg::K_PLAIN);
               end
            end
            default: begin
               phase_in = tekd_pkg::PH_IDLE;
            end
         endcase
      end
   end

endmodule

### design/tekd_checker.sv
// ----------------------------------------------------------------------------
// tekd_checker
// Port-level checks on the terminal escape key decoder, bound to its top.
// ----------------------------------------------------------------------------
module tekd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_key_kind,
   input logic [7:0] rsp_key_byte
);

   // Empty result register straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_kind) &&
                                 $stable(rsp_key_byte))
      else $error("stalled result changed");

   // Named keys carry no byte
   a_named_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_kind != tekd_pkg::K_PLAIN |-> rsp_key_byte == 8'h00)
      else $error("named key with non-zero byte");

   // Only defined key kinds
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_kind <= tekd_pkg::K_PGDN)
      else $error("undefined key kind");

   // Input never stalls while the result side is free
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind terminal_escape_key_decoder_unit tekd_checker u_tekd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_key_kind (rsp_key_kind),
   .rsp_key_byte (rsp_key_byte)
);

### verif/terminal_escape_key_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_unit_test
// Self-checking bench for the escape key decoder. A short table of directed
// beats covers the byte extremes, timeouts and a sample of key sequences. It is
// followed by random escape sequences, well formed and broken, sent under
// several idle and stall patterns. Every accepted key is checked against a
// local model of the sequence decoder.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BEATS = 1600;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      tekd_pkg::key_kind_type kind;
      logic [7:0]             code;
   } key_event_type;

   typedef struct packed {
      tekd_pkg::op_type       op;
      logic [7:0]             b;
      logic                   fixed;
      tekd_pkg::key_kind_type kind;
      logic [7:0]             code;
   } stim_row_type;

   // Directed beats; the key is typed in where the row has fixed set
   localparam int DIRECTED_ROWS = 22;
   localparam stim_row_type DIRECTED[DIRECTED_ROWS] = '{
      '{tekd_pkg::OP_BYTE,    8'h00,               1'b1, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    8'hFF,               1'b1, tekd_pkg::K_PLAIN, 8'hFF},
      '{tekd_pkg::OP_TIMEOUT, 8'hA5,               1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_ESC,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_TIMEOUT, 8'h00,       1'b1, tekd_pkg::K_PLAIN, tekd_pkg::CH_ESC},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_ESC,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_BRACKET, 1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_A,       1'b1, tekd_pkg::K_UP,    8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_ESC,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_BRACKET, 1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_5,       1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_TILDE,   1'b1, tekd_pkg::K_PGUP,  8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_ESC,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_SS3,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_H,       1'b1, tekd_pkg::K_HOME,  8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_ESC,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_BRACKET, 1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_NINE,    1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE, tekd_pkg::CH_TILDE, 1'b1, tekd_pkg::K_PLAIN, tekd_pkg::CH_ESC},
      '{tekd_pkg::OP_BYTE,    tekd_pkg::CH_ESC,     1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    8'hFF,               1'b0, tekd_pkg::K_PLAIN, 8'h00},
      '{tekd_pkg::OP_BYTE,    8'h80,               1'b0, tekd_pkg::K_PLAIN, 8'h00}
   };

   localparam logic [7:0] FINAL_LETTERS[6] = '{
      tekd_pkg::CH_A, tekd_pkg::CH_B, tekd_pkg::CH_C,
      tekd_pkg::CH_D, tekd_pkg::CH_H, tekd_pkg::CH_F
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = 1'b0;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_key_kind;
   logic [7:0] rsp_key_byte;

   // Local copy of the sequence state
   tekd_pkg::phase_type seq_phase = tekd_pkg::PH_IDLE;
   logic [7:0]          esc_first = 8'h00;
   logic [7:0]          esc_digit = 8'h00;

   key_event_type pending_keys[$];
   int            errors = 0;
   int            beats_sent = 0;
   int            cycles = 0;
   int            idle_pct = 0;
   int            stall_pct = 0;

   terminal_escape_key_decoder_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_byte_value (req_byte_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_kind   (rsp_key_kind),
      .rsp_key_byte   (rsp_key_byte)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Advance the decoder model by one beat; returns 1 when a key comes out
   function automatic bit decode_key(input tekd_pkg::op_type op, input logic [7:0] b,
                                     output key_event_type ev);
      bit emitted;
      emitted = 1'b0;
      ev.kind = tekd_pkg::K_PLAIN;
      ev.code = tekd_pkg::CH_ESC;
      if (op == tekd_pkg::OP_TIMEOUT) begin
         emitted = (seq_phase != tekd_pkg::PH_IDLE);
      end else begin
         case (seq_phase)
            tekd_pkg::PH_IDLE: begin
               if (b == tekd_pkg::CH_ESC) begin
                  seq_phase = tekd_pkg::PH_ESC;
               end else begin
                  emitted = 1'b1;
                  ev.code = b;
               end
            end
            tekd_pkg::PH_ESC: begin
               esc_first = b;
               seq_phase = tekd_pkg::PH_FIRST;
            end
            tekd_pkg::PH_FIRST: begin
               emitted = 1'b1;
               if (esc_first == tekd_pkg::CH_BRACKET && b >= tekd_pkg::CH_ZERO &&
                   b <= tekd_pkg::CH_NINE) begin
                  // hold the digit and wait for the tilde
                  esc_digit = b;
                  seq_phase = tekd_pkg::PH_DIGIT;
                  emitted = 1'b0;
               end else if (esc_first == tekd_pkg::CH_BRACKET) begin
                  case (b)
                     tekd_pkg::CH_A: ev.kind = tekd_pkg::K_UP;
                     tekd_pkg::CH_B: ev.kind = tekd_pkg::K_DOWN;
                     tekd_pkg::CH_C: ev.kind = tekd_pkg::K_RIGHT;
                     tekd_pkg::CH_D: ev.kind = tekd_pkg::K_LEFT;
                     tekd_pkg::CH_H: ev.kind = tekd_pkg::K_HOME;
                     tekd_pkg::CH_F: ev.kind = tekd_pkg::K_END;
                     default:        ev.kind = tekd_pkg::K_PLAIN;
                  endcase
               end else if (esc_first == tekd_pkg::CH_SS3) begin
                  if (b == tekd_pkg::CH_H) ev.kind = tekd_pkg::K_HOME;
                  else if (b == tekd_pkg::CH_F) ev.kind = tekd_pkg::K_END;
               end
            end
            default: begin
               emitted = 1'b1;
               if (b == tekd_pkg::CH_TILDE) begin
                  case (esc_digit)
                     tekd_pkg::CH_1, tekd_pkg::CH_7: ev.kind = tekd_pkg::K_HOME;
                     tekd_pkg::CH_3:                 ev.kind = tekd_pkg::K_DELETE;
                     tekd_pkg::CH_4, tekd_pkg::CH_8: ev.kind = tekd_pkg::K_END;
                     tekd_pkg::CH_5:                 ev.kind = tekd_pkg::K_PGUP;
                     tekd_pkg::CH_6:                 ev.kind = tekd_pkg::K_PGDN;
                     default:                        ev.kind = tekd_pkg::K_PLAIN;
                  endcase
               end
            end
         endcase
      end
      // named keys carry no byte
      if (ev.kind != tekd_pkg::K_PLAIN) ev.code = 8'h00;
      if (emitted) seq_phase = tekd_pkg::PH_IDLE;
      return emitted;
   endfunction

   function automatic stim_row_type beat(input tekd_pkg::op_type op, input logic [7:0] b);
      stim_row_type row;
      row = '{op, b, 1'b0, tekd_pkg::K_PLAIN, 8'h00};
      return row;
   endfunction

   // Drive one beat after a random gap, then record the key it should give
   task automatic send_beat(input stim_row_type row);
      key_event_type ev;
      bit            emitted;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_operation <= 1'($urandom_range(1));
         req_byte_value <= 8'($urandom_range(255));
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= row.op;
      req_byte_value <= row.b;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      emitted = decode_key(row.op, row.b, ev);
      if (row.fixed) begin
         ev.kind = row.kind;
         ev.code = row.code;
         pending_keys.push_back(ev);
      end else if (emitted) begin
         pending_keys.push_back(ev);
      end
   endtask

   task automatic wait_for_keys();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
   endtask

   // Build one random sequence, mostly well formed, and send it
   task automatic play_random_sequence();
      stim_row_type seq_q[$];
      int           pick;
      int           n;
      pick = $urandom_range(99);
      if (pick < 20) begin
         seq_q.push_back(beat(tekd_pkg::OP_BYTE, 8'($urandom_range(255))));
      end else if (pick < 25) begin
         seq_q.push_back(beat(tekd_pkg::OP_TIMEOUT, 8'($urandom_range(255))));
      end else begin
         seq_q.push_back(beat(tekd_pkg::OP_BYTE, tekd_pkg::CH_ESC));
         if (pick < 42) begin
            seq_q.push_back(beat(tekd_pkg::OP_BYTE, tekd_pkg::CH_BRACKET));
            if ($urandom_range(99) < 15)
               seq_q.push_back(beat(tekd_pkg::OP_BYTE, 8'($urandom_range(255))));
            else
               seq_q.push_back(beat(tekd_pkg::OP_BYTE,
                                    FINAL_LETTERS[3'($urandom_range(5))]));
         end else if (pick < 62) begin
            seq_q.push_back(beat(tekd_pkg::OP_BYTE, tekd_pkg::CH_BRACKET));
            seq_q.push_back(beat(tekd_pkg::OP_BYTE,
                                 tekd_pkg::CH_ZERO + 8'($urandom_range(9))));
            if ($urandom_range(9) == 0)
               seq_q.push_back(beat(tekd_pkg::OP_BYTE, 8'($urandom_range(255))));
            else
               seq_q.push_back(beat(tekd_pkg::OP_BYTE, tekd_pkg::CH_TILDE));
         end else if (pick < 72) begin
            seq_q.push_back(beat(tekd_pkg::OP_BYTE, tekd_pkg::CH_SS3));
            if ($urandom_range(9) == 0)
               seq_q.push_back(beat(tekd_pkg::OP_BYTE, 8'($urandom_range(255))));
            else
               seq_q.push_back(beat(tekd_pkg::OP_BYTE,
                                    $urandom_range(1) ? tekd_pkg::CH_H : tekd_pkg::CH_F));
         end else if (pick < 86) begin
            // broken tail of random bytes
            n = $urandom_range(1, 3);
            repeat (n) seq_q.push_back(beat(tekd_pkg::OP_BYTE, 8'($urandom_range(255))));
         end else begin
            // timeout part way through a sequence
            n = $urandom_range(2);
            if (n >= 1)
               seq_q.push_back(beat(tekd_pkg::OP_BYTE, $urandom_range(1) ?
                                    tekd_pkg::CH_BRACKET : tekd_pkg::CH_SS3));
            if (n == 2)
               seq_q.push_back(beat(tekd_pkg::OP_BYTE,
                                    tekd_pkg::CH_ZERO + 8'($urandom_range(9))));
            seq_q.push_back(beat(tekd_pkg::OP_TIMEOUT, 8'($urandom_range(255))));
         end
      end
      foreach (seq_q[i]) send_beat(seq_q[i]);
   endtask

   // Stall the result channel at the current rate
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Check each accepted key against the oldest expectation
   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_keys.size() == 0) begin
            $display("%0t: unexpected key: kind %0d byte %0d",
                     $time, rsp_key_kind, rsp_key_byte);
            errors++;
         end else begin
            want = pending_keys.pop_front();
            if (rsp_key_kind !== want.kind) begin
               $display("%0t: key_kind mismatch: expected %0d, actual %0d",
                        $time, want.kind, rsp_key_kind);
               errors++;
            end
            if (rsp_key_byte !== want.code) begin
               $display("%0t: key_byte mismatch: expected %0d, actual %0d",
                        $time, want.code, rsp_key_byte);
               errors++;
            end
         end
      end
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("terminal_escape_key_decoder_unit test failed");
         $finish;
      end
   end

   initial begin
      int phase_end;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling
      for (int i = 0; i < DIRECTED_ROWS; i++) send_beat(DIRECTED[i]);
      wait_for_keys();

      // random phases: none, sender idle, receiver stall, both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 69; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         phase_end = beats_sent + RANDOM_BEATS / 4;
         while (beats_sent < phase_end) play_random_sequence();
         // hold off the sender until every key has come back
         wait_for_keys();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_keys.size() == 0) begin
         $display("terminal_escape_key_decoder_unit test passed");
      end else begin
         $display("terminal_escape_key_decoder_unit test failed");
      end
      $finish;
   end

endmodule
